>>> src/ctdc_pkg.sv
// Shared types, constants and decode helpers for the color text display controller.
// Used by every module under src; depends on nothing else.
`default_nettype none

package ctdc_pkg;

   localparam int unsigned CHAR_RAM_BYTES_DEF = 4096;
   localparam int unsigned TEXT_COLS_DEF      = 80;
   localparam int unsigned TEXT_ROWS_DEF      = 25;
   localparam int unsigned COLOR_ENTRIES_DEF  = 16;

   localparam logic [23:0] FRAME_PERIOD_RST = 24'd133333;

   localparam logic [15:0] ALPHA_BASE    = 16'h2000;
   localparam logic [15:0] MIRROR_MASK   = 16'h7FFF;
   localparam logic [15:0] CMAP_SEL_MASK = 16'h7C00;
   localparam logic [15:0] CMAP_SEL_VAL  = 16'h7800;
   localparam logic [15:0] ADDR_VBLANK   = 16'hFFFC;
   localparam logic [15:0] ADDR_ID       = 16'hFFFE;
   localparam logic [14:0] WRAP_SPAN     = 15'h0800;
   localparam logic [7:0]  ID_HI         = 8'h0A;
   localparam logic [7:0]  ID_LO         = 8'h30;
   localparam logic [1:0]  SIZE_WORD     = 2'd2;

   localparam logic [7:0] BLINK_MASK_ON   = 8'h00;
   localparam logic [7:0] BLINK_MASK_OFF  = 8'hFF;
   localparam logic [7:0] BLINK_MASK_FAST = 8'h20;
   localparam logic [7:0] BLINK_MASK_SLOW = 8'h10;

   // width of a cursor offset relative to the display start
   localparam int unsigned REL_W = 14;

   typedef enum logic [1:0] {
      FUNC_READ  = 2'd0,
      FUNC_WRITE = 2'd1,
      FUNC_TICK  = 2'd2,
      FUNC_NOP   = 2'd3
   } func_type;

   typedef enum logic [4:0] {
      CRTC_CURSOR_START = 5'd10,
      CRTC_CURSOR_END   = 5'd11,
      CRTC_START_HI     = 5'd12,
      CRTC_START_LO     = 5'd13,
      CRTC_CURSOR_HI    = 5'd14,
      CRTC_CURSOR_LO    = 5'd15
   } crtc_reg_type;

   typedef enum logic [1:0] {
      BLINK_ON   = 2'd0,
      BLINK_OFF  = 2'd1,
      BLINK_FAST = 2'd2,
      BLINK_SLOW = 2'd3
   } blink_mode_type;

   typedef struct packed {
      logic [1:0]  func;
      logic [15:0] addr;
      logic [1:0]  size;
      logic [15:0] wdata;
      logic [15:0] elapsed_cycles;
   } req_type;

   typedef struct packed {
      logic [15:0] rdata;
      logic        frame_done;
      logic        cursor_shown;
      logic [6:0]  cursor_row;
      logic [6:0]  cursor_col;
      logic [4:0]  cursor_top_line;
      logic [5:0]  cursor_lines;
   } rsp_type;

   typedef struct packed {
      logic [15:0]      rdata;
      logic             frame_done;
      logic             shown;
      logic [REL_W-1:0] rel;
      logic [4:0]       top;
      logic [5:0]       lines;
   } pre_rsp_type;

   typedef struct packed {
      logic [15:0]      rdata;
      logic             frame_done;
      logic             shown;
      logic [REL_W-1:0] rel;
      logic [REL_W-1:0] quot;
      logic [4:0]       top;
      logic [5:0]       lines;
   } quot_rsp_type;

   // True when the access lands in the character RAM window.
   function automatic logic alpha_hit(input logic [15:0] addr, input logic [1:0] size,
                                      input logic [15:0] nbytes);
      logic [17:0] m;
      logic [17:0] last;
      logic        special;
      m       = {2'b00, addr & MIRROR_MASK};
      last    = {2'b00, ALPHA_BASE} + {1'b0, nbytes, 1'b0}
                - ((size == SIZE_WORD) ? 18'd2 : 18'd1);
      special = (addr[15:2] == ADDR_VBLANK[15:2]);
      return !special && (m >= {2'b00, ALPHA_BASE}) && (m <= last);
   endfunction

   // Byte offset into the character RAM, folded back once past the end.
   function automatic logic [15:0] alpha_off(input logic [15:0] addr,
                                             input logic [15:0] nbytes);
      logic [15:0] rel;
      rel = (addr & MIRROR_MASK) - ALPHA_BASE;
      return (rel >= nbytes) ? (rel - nbytes) : rel;
   endfunction

endpackage

`default_nettype wire

>>> src/ctdc_char_ram.sv
// Character and attribute RAM, split into even and odd byte banks so a word beat
// reads or writes both bytes together in the same cycle. Depends on ctdc_pkg.
`default_nettype none

module ctdc_char_ram #(
   parameter int unsigned CHAR_RAM_BYTES = ctdc_pkg::CHAR_RAM_BYTES_DEF
) (
   input  wire logic             clock,
   input  wire logic             acc_en,
   input  wire ctdc_pkg::req_type item,
   output logic [7:0]            ev_q,
   output logic [7:0]            od_q
);

   localparam int unsigned HALF = CHAR_RAM_BYTES / 2;
   localparam int unsigned OW   = $clog2(CHAR_RAM_BYTES);
   localparam int unsigned AW   = OW - 1;
   localparam logic [15:0] RAM_BYTES = 16'(CHAR_RAM_BYTES);
   localparam logic [OW-1:0] LAST_OFF = OW'(CHAR_RAM_BYTES - 1);

   logic [7:0]    even_mem_ff [HALF];
   logic [7:0]    odd_mem_ff  [HALF];
   logic [7:0]    ev_q_ff;
   logic [7:0]    od_q_ff;

   logic [15:0]   off_full;
   logic [OW-1:0] off;
   logic [OW-1:0] off_next;
   logic [AW-1:0] ev_addr;
   logic [AW-1:0] od_addr;
   logic          word;
   logic          wr;
   logic          ev_we;
   logic          od_we;
   logic [7:0]    ev_wbyte;
   logic [7:0]    od_wbyte;

   always_comb begin
      off_full = ctdc_pkg::alpha_off(item.addr, RAM_BYTES);
      off      = off_full[OW-1:0];
      off_next = (off == LAST_OFF) ? '0 : off + 1'b1;
      word     = (item.size == ctdc_pkg::SIZE_WORD);
      wr       = acc_en && (item.func == ctdc_pkg::FUNC_WRITE)
                 && ctdc_pkg::alpha_hit(item.addr, item.size, RAM_BYTES);
      // the odd byte of a pair always sits at off/2; the even one moves on an odd start
      od_addr  = off[OW-1:1];
      ev_addr  = off[0] ? off_next[OW-1:1] : off[OW-1:1];
      ev_we    = wr && (word || !off[0]);
      od_we    = wr && (word || off[0]);
      if (word) begin
         ev_wbyte = off[0] ? item.wdata[7:0] : item.wdata[15:8];
         od_wbyte = off[0] ? item.wdata[15:8] : item.wdata[7:0];
      end else begin
         ev_wbyte = item.wdata[7:0];
         od_wbyte = item.wdata[7:0];
      end
   end

   // character bytes drop bit 7
   always_ff @(posedge clock) begin
      if (ev_we) begin
         even_mem_ff[ev_addr] <= {1'b0, ev_wbyte[6:0]};
      end
      if (acc_en) begin
         ev_q_ff <= even_mem_ff[ev_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (od_we) begin
         odd_mem_ff[od_addr] <= od_wbyte;
      end
      if (acc_en) begin
         od_q_ff <= odd_mem_ff[od_addr];
      end
   end

   assign ev_q = ev_q_ff;
   assign od_q = od_q_ff;

endmodule

`default_nettype wire

>>> src/ctdc_core.sv
// Register file and frame timing: decodes one beat against the CRTC, color map,
// status and ID areas, updates state and forms the early result. Depends on ctdc_pkg.
`default_nettype none

module ctdc_core #(
   parameter int unsigned CHAR_RAM_BYTES = ctdc_pkg::CHAR_RAM_BYTES_DEF,
   parameter int unsigned TEXT_COLS      = ctdc_pkg::TEXT_COLS_DEF,
   parameter int unsigned TEXT_ROWS      = ctdc_pkg::TEXT_ROWS_DEF,
   parameter int unsigned COLOR_ENTRIES  = ctdc_pkg::COLOR_ENTRIES_DEF
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  fire,
   input  wire ctdc_pkg::req_type     item,
   input  wire logic [7:0]            ev_q,
   input  wire logic [7:0]            od_q,
   input  wire logic [23:0]           frame_period,
   output ctdc_pkg::pre_rsp_type      pre
);

   // only addr[4:1] selects a color entry
   localparam int unsigned CMAP_DEPTH = (COLOR_ENTRIES < 16) ? COLOR_ENTRIES : 16;
   localparam int unsigned CMAP_AW    = (CMAP_DEPTH > 1) ? $clog2(CMAP_DEPTH) : 1;
   localparam logic [13:0] SCREEN_CELLS = 14'(TEXT_COLS * TEXT_ROWS);
   localparam logic [15:0] RAM_BYTES    = 16'(CHAR_RAM_BYTES);

   logic [7:0]  crtc_regs_ff [32];
   logic [4:0]  crtc_index_ff;
   logic [11:0] color_map_ff [CMAP_DEPTH];
   logic [13:0] screen_start_ff, screen_start_in;
   logic [13:0] screen_end_ff, screen_end_in;
   logic [13:0] cursor_pending_ff, cursor_pending_in;
   logic [4:0]  cursor_top_ff, cursor_top_in;
   logic [5:0]  cursor_bottom_ff, cursor_bottom_in;
   logic [5:0]  cursor_height_ff, cursor_height_in;
   logic [7:0]  blink_mask_ff, blink_mask_in;
   logic [5:0]  frame_count_ff, frame_count_in;
   logic [31:0] cycle_accum_ff, cycle_accum_in;

   logic [15:0]        m;
   logic               word;
   logic               is_read, is_write, is_tick;
   logic               is_vbl, is_id, hit_alpha, hit_cmap, hit_index, hit_data;
   logic [3:0]         cmap_sel;
   logic               cmap_ok;
   logic [CMAP_AW-1:0] cmap_idx;
   logic [15:0]        off_full;
   logic [7:0]         ram_hi, ram_lo;
   logic               vblank;
   logic [15:0]        rdata;
   logic               wr_ok, index_we, reg_we, cmap_we;
   logic [7:0]         v;
   logic [7:0]         start_hi, start_lo, pend_hi, pend_lo;
   logic               shape_upd;
   logic [6:0]         h7;
   logic [31:0]        sum;
   logic [32:0]        diff;
   logic               frame;
   logic [5:0]         fc_next;
   logic               blink_ok, shape_ok, in_win;
   logic [14:0]        p;
   logic [13:0]        rel;

   always_comb begin
      m         = item.addr & ctdc_pkg::MIRROR_MASK;
      word      = (item.size == ctdc_pkg::SIZE_WORD);
      is_read   = (item.func == ctdc_pkg::FUNC_READ);
      is_write  = (item.func == ctdc_pkg::FUNC_WRITE);
      is_tick   = (item.func == ctdc_pkg::FUNC_TICK);
      is_vbl    = (item.addr[15:1] == ctdc_pkg::ADDR_VBLANK[15:1]);
      is_id     = (item.addr[15:1] == ctdc_pkg::ADDR_ID[15:1]);
      hit_alpha = ctdc_pkg::alpha_hit(item.addr, item.size, RAM_BYTES);
      hit_cmap  = ((m & ctdc_pkg::CMAP_SEL_MASK) == ctdc_pkg::CMAP_SEL_VAL);
      hit_index = (m[15:1] == 15'd0);
      hit_data  = (m[15:1] == 15'd1);
      cmap_sel  = item.addr[4:1];
      cmap_ok   = word && (5'(cmap_sel) < 5'(CMAP_DEPTH));
      cmap_idx  = cmap_sel[CMAP_AW-1:0];

      off_full  = ctdc_pkg::alpha_off(item.addr, RAM_BYTES);
      ram_hi    = off_full[0] ? od_q : ev_q;
      ram_lo    = off_full[0] ? ev_q : od_q;
      vblank    = (cycle_accum_ff >= {16'd0, frame_period[23:8]});

      rdata = '0;
      if (is_vbl) begin
         rdata = {15'd0, vblank};
      end else if (is_id) begin
         if (word) begin
            rdata = {ctdc_pkg::ID_HI, ctdc_pkg::ID_LO};
         end else if (item.addr[0]) begin
            rdata = {8'd0, ctdc_pkg::ID_LO};
         end else begin
            rdata = {8'd0, ctdc_pkg::ID_HI};
         end
      end else if (hit_alpha) begin
         rdata = word ? {ram_hi, ram_lo} : {8'd0, ram_hi};
      end else if (hit_cmap) begin
         if (cmap_ok) begin
            rdata = {4'd0, color_map_ff[cmap_idx]};
         end
      end else if (hit_data) begin
         rdata = {8'd0, crtc_regs_ff[crtc_index_ff]};
      end

      wr_ok    = is_write && !is_vbl && !is_id && !hit_alpha;
      index_we = fire && wr_ok && hit_index;
      reg_we   = fire && wr_ok && hit_data;
      cmap_we  = fire && wr_ok && hit_cmap && cmap_ok;

      // CRTC data beat
      v        = item.wdata[7:0];
      start_hi = (crtc_index_ff == ctdc_pkg::CRTC_START_HI) ? v
                 : crtc_regs_ff[ctdc_pkg::CRTC_START_HI];
      start_lo = (crtc_index_ff == ctdc_pkg::CRTC_START_LO) ? v
                 : crtc_regs_ff[ctdc_pkg::CRTC_START_LO];
      pend_hi  = (crtc_index_ff == ctdc_pkg::CRTC_CURSOR_HI) ? v
                 : crtc_regs_ff[ctdc_pkg::CRTC_CURSOR_HI];
      pend_lo  = (crtc_index_ff == ctdc_pkg::CRTC_CURSOR_LO) ? v
                 : crtc_regs_ff[ctdc_pkg::CRTC_CURSOR_LO];

      screen_start_in   = screen_start_ff;
      screen_end_in     = screen_end_ff;
      cursor_pending_in = cursor_pending_ff;
      cursor_top_in     = cursor_top_ff;
      cursor_bottom_in  = cursor_bottom_ff;
      cursor_height_in  = cursor_height_ff;
      blink_mask_in     = blink_mask_ff;
      shape_upd         = 1'b0;

      if (reg_we) begin
         case (crtc_index_ff)
            ctdc_pkg::CRTC_CURSOR_START: begin
               cursor_top_in = v[4:0];
               shape_upd     = 1'b1;
               case (v[6:5])
                  ctdc_pkg::BLINK_ON:   blink_mask_in = ctdc_pkg::BLINK_MASK_ON;
                  ctdc_pkg::BLINK_OFF:  blink_mask_in = ctdc_pkg::BLINK_MASK_OFF;
                  ctdc_pkg::BLINK_FAST: blink_mask_in = ctdc_pkg::BLINK_MASK_FAST;
                  ctdc_pkg::BLINK_SLOW: blink_mask_in = ctdc_pkg::BLINK_MASK_SLOW;
                  default:              blink_mask_in = ctdc_pkg::BLINK_MASK_ON;
               endcase
            end
            ctdc_pkg::CRTC_CURSOR_END: begin
               cursor_bottom_in = v[5:0];
               shape_upd        = 1'b1;
            end
            ctdc_pkg::CRTC_START_HI, ctdc_pkg::CRTC_START_LO: begin
               screen_start_in = {start_hi[5:0], start_lo};
               screen_end_in   = screen_start_in + SCREEN_CELLS;
            end
            ctdc_pkg::CRTC_CURSOR_HI, ctdc_pkg::CRTC_CURSOR_LO: begin
               cursor_pending_in = {pend_hi[5:0], pend_lo};
            end
            default: begin
            end
         endcase
      end

      // height is bottom - top + 1, saturated to six bits
      h7 = {1'b0, cursor_bottom_in} - {2'b00, cursor_top_in} + 7'd1;
      if (shape_upd && (cursor_bottom_in >= {1'b0, cursor_top_in})) begin
         cursor_height_in = (h7 > 7'd63) ? 6'd63 : h7[5:0];
      end

      // frame timing
      sum   = cycle_accum_ff + {16'd0, item.elapsed_cycles};
      diff  = {1'b0, sum} - {9'd0, frame_period};
      frame = is_tick && !diff[32];
      cycle_accum_in = cycle_accum_ff;
      frame_count_in = frame_count_ff;
      fc_next        = frame_count_ff + 6'd1;
      if (fire && frame) begin
         cycle_accum_in = diff[31:0];
         frame_count_in = fc_next;
      end else if (fire && is_tick) begin
         cycle_accum_in = sum;
      end

      // cursor window, wrapping a cursor below the start by one span
      blink_ok = (blink_mask_ff != ctdc_pkg::BLINK_MASK_OFF)
                 && ((blink_mask_ff[5:0] & fc_next) == 6'd0);
      shape_ok = (cursor_bottom_ff >= {1'b0, cursor_top_ff});
      p        = (cursor_pending_ff < screen_start_ff)
                 ? ({1'b0, cursor_pending_ff} + ctdc_pkg::WRAP_SPAN)
                 : {1'b0, cursor_pending_ff};
      in_win   = (p >= {1'b0, screen_start_ff}) && (p < {1'b0, screen_end_ff});
      rel      = p[13:0] - screen_start_ff;

      pre.rdata      = is_read ? rdata : 16'd0;
      pre.frame_done = frame;
      pre.shown      = frame && blink_ok && shape_ok && in_win;
      pre.rel        = rel;
      pre.top        = cursor_top_ff;
      pre.lines      = cursor_height_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 32; i++) begin
            crtc_regs_ff[i] <= '0;
         end
         for (int j = 0; j < int'(CMAP_DEPTH); j++) begin
            color_map_ff[j] <= '0;
         end
         crtc_index_ff     <= '0;
         screen_start_ff   <= '0;
         screen_end_ff     <= '0;
         cursor_pending_ff <= '0;
         cursor_top_ff     <= '0;
         cursor_bottom_ff  <= '0;
         cursor_height_ff  <= '0;
         blink_mask_ff     <= ctdc_pkg::BLINK_MASK_ON;
         frame_count_ff    <= '0;
         cycle_accum_ff    <= '0;
      end else begin
         if (index_we) begin
            crtc_index_ff <= item.wdata[4:0];
         end
         if (reg_we) begin
            crtc_regs_ff[crtc_index_ff] <= v;
         end
         if (cmap_we) begin
            color_map_ff[cmap_idx] <= item.wdata[11:0];
         end
         screen_start_ff   <= screen_start_in;
         screen_end_ff     <= screen_end_in;
         cursor_pending_ff <= cursor_pending_in;
         cursor_top_ff     <= cursor_top_in;
         cursor_bottom_ff  <= cursor_bottom_in;
         cursor_height_ff  <= cursor_height_in;
         blink_mask_ff     <= blink_mask_in;
         frame_count_ff    <= frame_count_in;
         cycle_accum_ff    <= cycle_accum_in;
      end
   end

endmodule

`default_nettype wire

>>> src/ctdc_cursor_div.sv
// Output pipeline: splits the cursor offset into row and column with a reciprocal
// multiply, then holds the result beat. Depends on ctdc_pkg.
`default_nettype none

module ctdc_cursor_div #(
   parameter int unsigned TEXT_COLS = ctdc_pkg::TEXT_COLS_DEF
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  pre_valid,
   output logic                       pre_ready,
   input  wire ctdc_pkg::pre_rsp_type pre,
   output logic                       rsp_valid,
   input  wire logic                  rsp_ready,
   output ctdc_pkg::rsp_type          rsp_data
);

   localparam int unsigned REL_W     = ctdc_pkg::REL_W;
   localparam int unsigned DIV_SHIFT = 22;
   localparam int unsigned DIV_RECIP = ((1 << DIV_SHIFT) + TEXT_COLS - 1) / TEXT_COLS;
   localparam int unsigned RECIP_W   = $clog2(DIV_RECIP + 1);
   localparam int unsigned PROD_W    = REL_W + RECIP_W;

   ctdc_pkg::pre_rsp_type  s2_ff;
   ctdc_pkg::quot_rsp_type s3_ff, s3_in;
   ctdc_pkg::rsp_type      rsp_ff, rsp_in;
   logic                   s2_vld_ff, s3_vld_ff, rsp_vld_ff;
   logic                   s2_rdy, s3_rdy, rsp_rdy;

   logic [PROD_W-1:0] prod;
   logic [REL_W-1:0]  cols_k;
   logic [REL_W-1:0]  qcols;
   logic [REL_W-1:0]  col_full;

   assign rsp_rdy   = !rsp_vld_ff || rsp_ready;
   assign s3_rdy    = !s3_vld_ff || rsp_rdy;
   assign s2_rdy    = !s2_vld_ff || s3_rdy;
   assign pre_ready = s2_rdy;

   always_comb begin
      prod              = PROD_W'(s2_ff.rel) * PROD_W'(DIV_RECIP);
      s3_in.rdata       = s2_ff.rdata;
      s3_in.frame_done  = s2_ff.frame_done;
      s3_in.shown       = s2_ff.shown;
      s3_in.rel         = s2_ff.rel;
      s3_in.quot        = REL_W'(prod >> DIV_SHIFT);
      s3_in.top         = s2_ff.top;
      s3_in.lines       = s2_ff.lines;

      cols_k   = REL_W'(TEXT_COLS);
      qcols    = s3_ff.quot * cols_k;
      col_full = s3_ff.rel - qcols;

      rsp_in.rdata           = s3_ff.rdata;
      rsp_in.frame_done      = s3_ff.frame_done;
      rsp_in.cursor_shown    = s3_ff.shown;
      rsp_in.cursor_row      = s3_ff.shown ? s3_ff.quot[6:0] : 7'd0;
      rsp_in.cursor_col      = s3_ff.shown ? col_full[6:0] : 7'd0;
      rsp_in.cursor_top_line = s3_ff.shown ? s3_ff.top : 5'd0;
      rsp_in.cursor_lines    = s3_ff.shown ? s3_ff.lines : 6'd0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_vld_ff  <= 1'b0;
         s3_vld_ff  <= 1'b0;
         rsp_vld_ff <= 1'b0;
      end else begin
         if (s2_rdy) begin
            s2_vld_ff <= pre_valid;
         end
         if (s3_rdy) begin
            s3_vld_ff <= s2_vld_ff;
         end
         if (rsp_rdy) begin
            rsp_vld_ff <= s3_vld_ff;
         end
      end
   end

   // payload advances only with a live beat
   always_ff @(posedge clock) begin
      if (pre_valid && s2_rdy) begin
         s2_ff <= pre;
      end
      if (s2_vld_ff && s3_rdy) begin
         s3_ff <= s3_in;
      end
      if (s3_vld_ff && rsp_rdy) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_vld_ff;
   assign rsp_data  = rsp_ff;

endmodule

`default_nettype wire

>>> src/color_text_display_controller_unit.sv
// Color text display controller, bus side: accepts one bus read, bus write or time
// tick per cycle, unless rsp_ready holds it back, and returns exactly one result beat
// for each, in order. Sustained rate is one item per clock while rsp_ready holds. The
// request register also catches the registered read of the character RAM, the register
// file and frame timing feed the s2 register, and the s3 and result registers hold the
// reciprocal-multiply split of the cursor offset into row and column. The request
// and result sides are decoupled by the pipeline registers, so new beats are taken
// while a result waits, until those registers fill. CHAR_RAM_BYTES must be even (the
// RAM is banked by byte parity); the RAM has no reset and a byte reads back only after
// it has been written. frame_period is written on the csr channel, which is always
// ready; the user must write it only while no beat is in flight (not enforced).
// Depends on ctdc_pkg, ctdc_char_ram, ctdc_core and ctdc_cursor_div.
`default_nettype none

module color_text_display_controller_unit #(
   parameter int unsigned CHAR_RAM_BYTES = ctdc_pkg::CHAR_RAM_BYTES_DEF,
   parameter int unsigned TEXT_COLS      = ctdc_pkg::TEXT_COLS_DEF,
   parameter int unsigned TEXT_ROWS      = ctdc_pkg::TEXT_ROWS_DEF,
   parameter int unsigned COLOR_ENTRIES  = ctdc_pkg::COLOR_ENTRIES_DEF
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_ready,
   input  wire ctdc_pkg::req_type req_data,
   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   output ctdc_pkg::rsp_type      rsp_data,
   input  wire logic              csr_valid,
   output logic                   csr_ready,
   input  wire logic [23:0]       csr_data
);

   logic                  s1_vld_ff;
   ctdc_pkg::req_type     s1_item_ff;
   logic [23:0]           frame_period_ff;
   logic                  accept;
   logic                  fire;
   logic                  pre_ready;
   logic [7:0]            ev_q, od_q;
   ctdc_pkg::pre_rsp_type pre;

   assign csr_ready = 1'b1;
   assign req_ready = !s1_vld_ff || pre_ready;
   assign accept    = req_valid && req_ready;
   assign fire      = s1_vld_ff && pre_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff       <= 1'b0;
         frame_period_ff <= ctdc_pkg::FRAME_PERIOD_RST;
      end else begin
         if (req_ready) begin
            s1_vld_ff <= req_valid;
         end
         if (csr_valid && csr_ready) begin
            frame_period_ff <= csr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_item_ff <= req_data;
      end
   end

   // RAM is read and written on the request beat itself, in step with the stage-1 load
   ctdc_char_ram #(
      .CHAR_RAM_BYTES(CHAR_RAM_BYTES)
   ) u_char_ram (
      .clock (clock),
      .acc_en(accept),
      .item  (req_data),
      .ev_q  (ev_q),
      .od_q  (od_q)
   );

   ctdc_core #(
      .CHAR_RAM_BYTES(CHAR_RAM_BYTES),
      .TEXT_COLS     (TEXT_COLS),
      .TEXT_ROWS     (TEXT_ROWS),
      .COLOR_ENTRIES (COLOR_ENTRIES)
   ) u_core (
      .clock       (clock),
      .reset       (reset),
      .fire        (fire),
      .item        (s1_item_ff),
      .ev_q        (ev_q),
      .od_q        (od_q),
      .frame_period(frame_period_ff),
      .pre         (pre)
   );

   ctdc_cursor_div #(
      .TEXT_COLS(TEXT_COLS)
   ) u_cursor_div (
      .clock    (clock),
      .reset    (reset),
      .pre_valid(s1_vld_ff),
      .pre_ready(pre_ready),
      .pre      (pre),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_data (rsp_data)
   );

endmodule

`default_nettype wire
